[hdl/cbs_pkg.sv]
// ---------------------------------------------------------------------------
// cbs_pkg
// shared types and constants of the channel breakout signal block
// ---------------------------------------------------------------------------
package cbs_pkg;

    localparam int TIME_W      = 64;
    localparam int LOOKBACK_W  = 10;
    localparam int TRAIL_W     = 6;
    localparam int GATE_W      = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 10;

    localparam logic [CFG_INDEX_W-1:0] CFG_ENTRY_LOOKBACK = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXIT_LOOKBACK  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRAIL_HALF_ATR = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TREND_GATE     = 2'd3;

    localparam logic [LOOKBACK_W-1:0] ENTRY_LOOKBACK_RST = 10'd192;
    localparam logic [LOOKBACK_W-1:0] EXIT_LOOKBACK_RST  = 10'd288;
    localparam logic [TRAIL_W-1:0]    TRAIL_RST          = 6'd0;

    localparam logic [GATE_W-1:0] GATE_OFF   = 2'd0;
    localparam logic [GATE_W-1:0] GATE_CLOSE = 2'd1;
    localparam logic [GATE_W-1:0] GATE_FAST  = 2'd2;
    localparam logic [GATE_W-1:0] GATE_BOTH  = 2'd3;

    localparam logic SIG_ENTER = 1'b0;
    localparam logic SIG_EXIT  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EVAL
    } state_t;

    typedef struct packed {
        logic shift;
        logic push;
    } chain_ctrl_t;

endpackage

[hdl/channel_breakout_signal_top.sv]
// ---------------------------------------------------------------------------
// channel_breakout_signal_top
// long-only channel breakout with trailing stop, one price bar per item
// ---------------------------------------------------------------------------
// Each bar is accepted in the idle state; then, in the scan state, the
// chain of cells rotates once past a single max/min compare point at its
// tail, and the evaluation state pushes the bar's high and low. The next
// bar is accepted once the block is back in the idle state. A result item
// sits in an output register, so the block takes the next bar while a
// result still waits; only a second result stalls evaluation. The ring
// needs no clearing pass after reset. The user writes configuration through
// the cfg port only while no bar is in flight; the block does not check it.
module channel_breakout_signal_top #(
    parameter int RING_DEPTH  = 512,
    parameter int PRICE_WIDTH = 32,
    localparam int IN_BITS    = 6 * PRICE_WIDTH + cbs_pkg::TIME_W,
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // config write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cbs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cbs_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input items
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // close_price, high_price, low_price, fast_average, slow_average,
    // true_range_average, close_time, zero fill
    input  logic [IN_TDATA_W-1:0]           s_axis_tdata,
    // fast_average_valid, slow_average_valid, true_range_valid
    input  logic [2:0]                      s_axis_tuser,
    // result items
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // signal_time
    output logic [cbs_pkg::TIME_W-1:0]      m_axis_tdata,
    // signal_kind, exit_by_trail
    output logic [1:0]                      m_axis_tuser
);

    import cbs_pkg::*;

    localparam int P    = PRICE_WIDTH;
    localparam int CW   = $clog2(RING_DEPTH + 1);
    localparam int JW   = $clog2(RING_DEPTH);
    localparam int XW   = (CW > LOOKBACK_W) ? CW : LOOKBACK_W;
    localparam int DW   = P + TRAIL_W;
    localparam int SW   = P + TRAIL_W + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(RING_DEPTH);
    localparam logic [JW-1:0] LAST_J  = JW'(RING_DEPTH - 1);

    // configuration
    logic [LOOKBACK_W-1:0] entry_lb_reg, entry_lb_next;
    logic [LOOKBACK_W-1:0] exit_lb_reg, exit_lb_next;
    logic [TRAIL_W-1:0]    trail_reg, trail_next;
    logic [GATE_W-1:0]     gate_mode_reg, gate_mode_next;

    // control
    state_t                state_reg, state_next;
    logic [JW-1:0]         cnt_reg, cnt_next;
    logic [CW-1:0]         filled_reg, filled_next;
    logic                  holding_reg, holding_next;
    logic [P-1:0]          peak_reg, peak_next;
    logic                  out_valid_reg, out_valid_next;

    // latched bar
    logic [P-1:0]          close_reg, high_reg, low_reg;
    logic [TIME_W-1:0]     time_reg;
    logic [DW-1:0]         dist_reg;
    logic                  trail_on_reg, gate_ok_reg;
    logic                  entry_fill_reg, exit_fill_reg;
    logic [JW-1:0]         entry_start_reg, exit_start_reg;
    logic [P-1:0]          max_reg, min_reg;

    // result
    logic                  out_kind_reg, out_trail_reg;
    logic [TIME_W-1:0]     out_time_reg;

    // input fields
    logic [P-1:0]          in_close, in_high, in_low, in_fast, in_slow, in_atr;
    logic [TIME_W-1:0]     in_time;
    logic                  in_fast_ok, in_slow_ok, in_atr_ok;

    logic                  accept;
    logic [CW-1:0]         entry_n, exit_n;
    logic [CW-1:0]         entry_start, exit_start;
    logic                  gate_ok;

    chain_ctrl_t           chain_ctrl;
    logic [P-1:0]          tail_high, tail_low;

    logic                  entry_win, exit_win;
    logic [P-1:0]          peak_new;
    logic [SW-1:0]         twice_peak, lhs;
    logic                  low_break, stop_break, entry_fire, exit_fire, fire, stall;
    logic                  load_out;

    assign in_close   = s_axis_tdata[0 +: P];
    assign in_high    = s_axis_tdata[P +: P];
    assign in_low     = s_axis_tdata[2*P +: P];
    assign in_fast    = s_axis_tdata[3*P +: P];
    assign in_slow    = s_axis_tdata[4*P +: P];
    assign in_atr     = s_axis_tdata[5*P +: P];
    assign in_time    = s_axis_tdata[6*P +: TIME_W];
    assign in_fast_ok = s_axis_tuser[0];
    assign in_slow_ok = s_axis_tuser[1];
    assign in_atr_ok  = s_axis_tuser[2];

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // config decode
    always_comb
    begin
        entry_lb_next  = entry_lb_reg;
        exit_lb_next   = exit_lb_reg;
        trail_next     = trail_reg;
        gate_mode_next = gate_mode_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ENTRY_LOOKBACK: entry_lb_next  = cfg_data[LOOKBACK_W-1:0];
                CFG_EXIT_LOOKBACK:  exit_lb_next   = cfg_data[LOOKBACK_W-1:0];
                CFG_TRAIL_HALF_ATR: trail_next     = cfg_data[TRAIL_W-1:0];
                CFG_TREND_GATE:     gate_mode_next = cfg_data[GATE_W-1:0];
                default:            entry_lb_next  = entry_lb_reg;
            endcase
        end
    end

    // effective lookbacks, clamped to 1..RING_DEPTH
    always_comb
    begin
        if (entry_lb_reg == '0)
            entry_n = CW'(1);
        else if (XW'(entry_lb_reg) > XW'(RING_DEPTH))
            entry_n = DEPTH_C;
        else
            entry_n = CW'(entry_lb_reg);

        if (exit_lb_reg == '0)
            exit_n = CW'(1);
        else if (XW'(exit_lb_reg) > XW'(RING_DEPTH))
            exit_n = DEPTH_C;
        else
            exit_n = CW'(exit_lb_reg);

        entry_start = DEPTH_C - entry_n;
        exit_start  = DEPTH_C - exit_n;
    end

    // trend gate
    always_comb
    begin
        unique case (gate_mode_reg)
            GATE_OFF:   gate_ok = 1'b1;
            GATE_CLOSE: gate_ok = in_slow_ok && (in_close > in_slow);
            GATE_FAST:  gate_ok = in_fast_ok && in_slow_ok && (in_fast > in_slow);
            GATE_BOTH:  gate_ok = in_fast_ok && in_slow_ok && (in_close > in_slow)
                                  && (in_fast > in_slow);
            default:    gate_ok = 1'b0;
        endcase
    end

    // evaluation of the scanned bar
    always_comb
    begin
        peak_new   = (close_reg > peak_reg) ? close_reg : peak_reg;
        twice_peak = SW'({peak_new, 1'b0});
        lhs        = SW'({close_reg, 1'b0}) + SW'(dist_reg);
        low_break  = exit_fill_reg && (close_reg <= min_reg);
        stop_break = trail_on_reg && (SW'(dist_reg) < twice_peak) && (lhs <= twice_peak);
        entry_fire = !holding_reg && entry_fill_reg && (close_reg > max_reg) && gate_ok_reg;
        exit_fire  = holding_reg && (low_break || stop_break);
        fire       = entry_fire || exit_fire;
        stall      = fire && out_valid_reg && !m_axis_tready;
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        filled_next     = filled_reg;
        holding_next    = holding_reg;
        peak_next       = peak_reg;
        chain_ctrl      = '0;
        load_out        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                chain_ctrl.shift = 1'b1;
                if (cnt_reg == LAST_J)
                begin
                    cnt_next   = '0;
                    state_next = ST_EVAL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_EVAL:
            begin
                if (!stall)
                begin
                    chain_ctrl.shift = 1'b1;
                    chain_ctrl.push  = 1'b1;
                    load_out         = fire;
                    if (filled_reg != DEPTH_C)
                        filled_next = filled_reg + 1'b1;
                    if (entry_fire)
                    begin
                        holding_next = 1'b1;
                        peak_next    = close_reg;
                    end
                    else if (exit_fire)
                    begin
                        holding_next = 1'b0;
                        peak_next    = '0;
                    end
                    else if (holding_reg)
                    begin
                        peak_next = peak_new;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = (out_valid_reg && !m_axis_tready) || load_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            filled_reg    <= '0;
            holding_reg   <= 1'b0;
            peak_reg      <= '0;
            out_valid_reg <= 1'b0;
            entry_lb_reg  <= ENTRY_LOOKBACK_RST;
            exit_lb_reg   <= EXIT_LOOKBACK_RST;
            trail_reg     <= TRAIL_RST;
            gate_mode_reg <= GATE_BOTH;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            filled_reg    <= filled_next;
            holding_reg   <= holding_next;
            peak_reg      <= peak_next;
            out_valid_reg <= out_valid_next;
            entry_lb_reg  <= entry_lb_next;
            exit_lb_reg   <= exit_lb_next;
            trail_reg     <= trail_next;
            gate_mode_reg <= gate_mode_next;
        end
    end

    // tail of the chain shows bars oldest first; only the last n count
    assign entry_win = (cnt_reg >= entry_start_reg);
    assign exit_win  = (cnt_reg >= exit_start_reg);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            close_reg       <= in_close;
            high_reg        <= in_high;
            low_reg         <= in_low;
            time_reg        <= in_time;
            dist_reg        <= DW'(trail_reg) * DW'(in_atr);
            trail_on_reg    <= in_atr_ok && (in_atr != '0) && (trail_reg != '0);
            gate_ok_reg     <= gate_ok;
            entry_fill_reg  <= (filled_reg >= entry_n);
            exit_fill_reg   <= (filled_reg >= exit_n);
            entry_start_reg <= entry_start[JW-1:0];
            exit_start_reg  <= exit_start[JW-1:0];
            max_reg         <= '0;
            min_reg         <= '1;
        end
        else if (state_reg == ST_SCAN)
        begin
            if (entry_win && (tail_high > max_reg))
                max_reg <= tail_high;
            if (exit_win && (tail_low < min_reg))
                min_reg <= tail_low;
        end
        if (load_out)
        begin
            out_kind_reg  <= exit_fire ? SIG_EXIT : SIG_ENTER;
            out_trail_reg <= exit_fire && stop_break;
            out_time_reg  <= time_reg;
        end
    end

    cbs_chain #(
        .DEPTH (RING_DEPTH),
        .WIDTH (P)
    ) u_chain (
        .clk       (clk),
        .ctrl      (chain_ctrl),
        .push_high (high_reg),
        .push_low  (low_reg),
        .tail_high (tail_high),
        .tail_low  (tail_low)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_time_reg;
    assign m_axis_tuser  = {out_trail_reg, out_kind_reg};

`ifndef ASSERT_OFF
    a_filled_bound: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= DEPTH_C)
        else $error("fill count above ring depth");

    a_result_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_EVAL)
        else $error("result raised outside evaluation");

    a_position_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (holding_reg != $past(holding_reg)) |-> $past(state_reg) == ST_EVAL)
        else $error("position changed outside evaluation");

    a_scan_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL) |-> (cnt_reg == '0))
        else $error("evaluation before full chain rotation");
`endif

endmodule

[hdl/cbs_cell.sv]
// ---------------------------------------------------------------------------
// cbs_cell
// one cell of the price chain: holds one bar high and low
// ---------------------------------------------------------------------------
module cbs_cell #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] d_high,
    input  logic [WIDTH-1:0] d_low,
    output logic [WIDTH-1:0] q_high,
    output logic [WIDTH-1:0] q_low
);

    logic [WIDTH-1:0] high_reg;
    logic [WIDTH-1:0] low_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            high_reg <= d_high;
            low_reg  <= d_low;
        end
    end

    assign q_high = high_reg;
    assign q_low  = low_reg;

endmodule

[hdl/cbs_chain.sv]
// ---------------------------------------------------------------------------
// cbs_chain
// row of cells, newest bar in cell 0; rotates for a scan, shifts for a push
// ---------------------------------------------------------------------------
module cbs_chain #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 32
) (
    input  logic                clk,
    input  cbs_pkg::chain_ctrl_t ctrl,
    input  logic [WIDTH-1:0]    push_high,
    input  logic [WIDTH-1:0]    push_low,
    output logic [WIDTH-1:0]    tail_high,
    output logic [WIDTH-1:0]    tail_low
);

    import cbs_pkg::*;

    logic [WIDTH-1:0] high_q [DEPTH];
    logic [WIDTH-1:0] low_q  [DEPTH];
    logic [WIDTH-1:0] head_high;
    logic [WIDTH-1:0] head_low;

    // wrap the tail around during a scan, take the new bar on a push
    assign head_high = ctrl.push ? push_high : high_q[DEPTH-1];
    assign head_low  = ctrl.push ? push_low  : low_q[DEPTH-1];

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++)
        begin : g_cell
            if (k == 0)
            begin : g_head
                cbs_cell #(.WIDTH(WIDTH)) u_cell (
                    .clk    (clk),
                    .en     (ctrl.shift),
                    .d_high (head_high),
                    .d_low  (head_low),
                    .q_high (high_q[k]),
                    .q_low  (low_q[k])
                );
            end
            else
            begin : g_body
                cbs_cell #(.WIDTH(WIDTH)) u_cell (
                    .clk    (clk),
                    .en     (ctrl.shift),
                    .d_high (high_q[k-1]),
                    .d_low  (low_q[k-1]),
                    .q_high (high_q[k]),
                    .q_low  (low_q[k])
                );
            end
        end
    endgenerate

    assign tail_high = high_q[DEPTH-1];
    assign tail_low  = low_q[DEPTH-1];

endmodule
